[rtl/core/tea_pkg.sv]
`default_nettype none

package tea_pkg;

  localparam logic [31:0] TEA_DELTA = 32'h9e3779b9;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned KEY_WORDS = 4;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3 = 3'd3;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } tea_cmd_e;

  typedef struct packed {
    tea_cmd_e    cmd;
    logic [31:0] y;
    logic [31:0] z;
    logic        last;
  } tea_word_t;

  typedef logic [KEY_WORDS-1:0][31:0] tea_key_t;

  typedef struct packed {
    logic adv;
    logic busy;
  } tea_bk_stat_t;

endpackage

`default_nettype wire

[rtl/core/tea_front.sv]
`default_nettype none

module tea_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                command_i,
  input  logic [31:0]         first_word_i,
  input  logic [31:0]         second_word_i,
  input  logic                last_block_i,
  input  logic                pop_i,
  output logic                head_valid_o,
  output tea_pkg::tea_word_t  head_o
);
  import tea_pkg::*;

  tea_word_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  tea_word_t  wr_word;

  always_comb begin
    wr_word.cmd  = command_i ? CMD_DECRYPT : CMD_ENCRYPT;
    wr_word.y    = first_word_i;
    wr_word.z    = second_word_i;
    wr_word.last = last_block_i;
  end

  assign in_stall_o   = cnt_q == 2'd2;
  assign head_valid_o = cnt_q != 2'd0;
  assign head_o       = mem_q[rd_ptr_q];
  assign push         = in_valid_i && !in_stall_o;
  assign pop          = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_word;
    end
  end

endmodule

`default_nettype wire

[rtl/core/tea_stage.sv]
`default_nettype none

module tea_stage #(
  parameter bit          PHASE   = 1'b0,
  parameter logic [31:0] ENC_SUM = 32'h0,
  parameter logic [31:0] DEC_SUM = 32'h0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  tea_pkg::tea_word_t word_i,
  input  tea_pkg::tea_key_t  key_i,
  output logic               valid_o,
  output tea_pkg::tea_word_t word_o
);
  import tea_pkg::*;

  logic        upd_y;
  logic [31:0] src, dst, sum, ka, kb, mix, res;
  logic        valid_q;
  tea_word_t   word_q, word_d;

  // encrypt: even half updates y; decrypt: even half updates z
  assign upd_y = (PHASE == 1'b0) ^ (word_i.cmd == CMD_DECRYPT);
  assign src   = upd_y ? word_i.z : word_i.y;
  assign dst   = upd_y ? word_i.y : word_i.z;
  assign ka    = upd_y ? key_i[0] : key_i[2];
  assign kb    = upd_y ? key_i[1] : key_i[3];
  assign sum   = (word_i.cmd == CMD_DECRYPT) ? DEC_SUM : ENC_SUM;
  assign mix   = ({src[27:0], 4'b0} + ka) ^ (src + sum) ^ ({5'b0, src[31:5]} + kb);
  assign res   = (word_i.cmd == CMD_DECRYPT) ? dst - mix : dst + mix;

  always_comb begin
    word_d = word_i;
    if (upd_y) begin
      word_d.y = res;
    end else begin
      word_d.z = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

[rtl/core/tea_back.sv]
`default_nettype none

module tea_back #(
  parameter int unsigned ROUNDS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  tea_pkg::tea_word_t    word_i,
  input  tea_pkg::tea_key_t     key_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output tea_pkg::tea_word_t    word_o,
  output tea_pkg::tea_bk_stat_t stat_o
);
  import tea_pkg::*;

  localparam int unsigned NSTG = 2 * ROUNDS;

  logic      vld [NSTG+1];
  tea_word_t stg [NSTG+1];
  logic      adv;

  // whole pipe holds while the finished word waits
  assign adv    = !(vld[NSTG] && out_stall_i);
  assign vld[0] = valid_i;
  assign stg[0] = word_i;

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    localparam int unsigned R = s / 2;
    localparam logic [31:0] ENC_SUM = 32'(TEA_DELTA * 32'(R + 1));
    localparam logic [31:0] DEC_SUM = 32'(TEA_DELTA * 32'(ROUNDS - R));

    tea_stage #(
      .PHASE   (1'(s % 2)),
      .ENC_SUM (ENC_SUM),
      .DEC_SUM (DEC_SUM)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (vld[s]),
      .word_i  (stg[s]),
      .key_i   (key_i),
      .valid_o (vld[s+1]),
      .word_o  (stg[s+1])
    );
  end

  always_comb begin
    stat_o.busy = 1'b0;
    for (int i = 1; i <= NSTG; i++) begin
      stat_o.busy = stat_o.busy | vld[i];
    end
    stat_o.adv = adv;
  end

  assign out_valid_o = vld[NSTG];
  assign word_o      = stg[NSTG];

endmodule

`default_nettype wire

[rtl/core/tea_block_cipher.sv]
// TEA block cipher, ECB, one 64-bit block per word.
// Input channel: in_valid_i/in_stall_o with command_i (0 encrypt, 1 decrypt),
// first_word_i (y), second_word_i (z) and last_block_i. A word is taken at a
// clock edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o/out_stall_i with first_result_o,
// second_result_o and last_result_o (copy of last_block_i).
// Key: four 32-bit registers written through cfg_valid_i/cfg_ready_o with
// cfg_index_i 0..3 and cfg_data_i; other indexes are ignored. cfg_ready_o is
// always high. Write the key only while no block is in flight.
// Path: the accept edge writes the 2-entry input queue, then the word passes
// through each of the 2*ROUNDS half-round stage registers in turn before
// out_valid_o rises.
// Throughput: one block per cycle while the result is not stalled.
// A stalled result freezes the round pipeline; the input queue keeps taking
// words until it holds two, then raises in_stall_o.
// Reset clears the key to zero and empties the queue and the pipeline.
`default_nettype none

module tea_block_cipher #(
  parameter int unsigned ROUNDS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic [31:0]                  first_word_i,
  input  logic [31:0]                  second_word_i,
  input  logic                         last_block_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [31:0]                  first_result_o,
  output logic [31:0]                  second_result_o,
  output logic                         last_result_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tea_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i
);
  import tea_pkg::*;

  tea_key_t     key_q, key_d;
  logic         fe_valid;
  tea_word_t    fe_word;
  tea_word_t    bk_word;
  tea_bk_stat_t bk_stat;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    key_d = key_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_KEY_WORD0: key_d[0] = cfg_data_i;
        REG_KEY_WORD1: key_d[1] = cfg_data_i;
        REG_KEY_WORD2: key_d[2] = cfg_data_i;
        REG_KEY_WORD3: key_d[3] = cfg_data_i;
        default:       key_d    = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  tea_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .first_word_i  (first_word_i),
    .second_word_i (second_word_i),
    .last_block_i  (last_block_i),
    .pop_i         (bk_stat.adv),
    .head_valid_o  (fe_valid),
    .head_o        (fe_word)
  );

  tea_back #(
    .ROUNDS (ROUNDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (fe_valid),
    .word_i      (fe_word),
    .key_i       (key_q),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .word_o      (bk_word),
    .stat_o      (bk_stat)
  );

  assign first_result_o  = bk_word.y;
  assign second_result_o = bk_word.z;
  assign last_result_o   = bk_word.last;

  a_stall_freezes_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> !bk_stat.adv)
    else $error("pipeline advanced under a stalled result");

  a_full_queue_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> fe_valid)
    else $error("input stalled with empty queue");

  a_issue_reaches_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fe_valid && bk_stat.adv |=> bk_stat.busy)
    else $error("issued word lost in pipeline");

endmodule

`default_nettype wire

[tb/tb_tea_block_cipher.sv]
`timescale 1ns / 1ps

module tb_tea_block_cipher;
  import tea_pkg::*;

  localparam int unsigned ROUNDS = 32;
  localparam int unsigned LATENCY = 2 * ROUNDS + 1;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 160;
  localparam int unsigned PRESSURE_PHASE = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX = '1;

  typedef struct packed {
    logic [31:0] y;
    logic [31:0] z;
    logic        last;
  } tea_block_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 command_i = 1'b0;
  logic [31:0]          first_word_i = '0;
  logic [31:0]          second_word_i = '0;
  logic                 last_block_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [31:0]          first_result_o;
  logic [31:0]          second_result_o;
  logic                 last_result_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0]          cfg_data_i = '0;

  tea_word_t  block_feed_q[$];
  tea_block_t tea_out_q[$];
  tea_word_t  word_on_port;
  tea_key_t   key_mirror = '0;
  int         mismatch_count = 0;
  int         feed_idle_pct = 0;
  int         drain_stall_pct = 0;
  int         feed_gap = 0;
  int         drain_gap = 0;
  logic       hold_start = 1'b0;
  logic       long_hold = 1'b0;

  tea_block_cipher #(
    .ROUNDS(ROUNDS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .first_word_i   (first_word_i),
    .second_word_i  (second_word_i),
    .last_block_i   (last_block_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .first_result_o (first_result_o),
    .second_result_o(second_result_o),
    .last_result_o  (last_result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [31:0] tea_mix(logic [31:0] v, logic [31:0] sum,
                                          logic [31:0] ka, logic [31:0] kb);
    return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
  endfunction

  function automatic tea_block_t tea_transform(tea_word_t w, tea_key_t k);
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] sum;
    tea_block_t  res;
    y = w.y;
    z = w.z;
    if (w.cmd == CMD_DECRYPT) begin
      sum = TEA_DELTA * 32'(ROUNDS);
      for (int r = 0; r < ROUNDS; r++) begin
        z -= tea_mix(y, sum, k[2], k[3]);
        y -= tea_mix(z, sum, k[0], k[1]);
        sum -= TEA_DELTA;
      end
    end else begin
      sum = '0;
      for (int r = 0; r < ROUNDS; r++) begin
        sum += TEA_DELTA;
        y += tea_mix(z, sum, k[0], k[1]);
        z += tea_mix(y, sum, k[2], k[3]);
      end
    end
    res.y = y;
    res.z = z;
    res.last = w.last;
    return res;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 32'h1 << $urandom_range(31);
      3: return ~(32'h1 << $urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR at %0t ns: %s got %h expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx <= REG_KEY_WORD3) key_mirror[idx[1:0]] = data;
  endtask

  task automatic load_key(input tea_key_t k);
    // unmapped index must leave the key alone
    if ($urandom_range(1))
      write_cfg(CFG_IDX_W'($urandom_range(CFG_IDX_MAX, REG_KEY_WORD3 + 1)), $urandom);
    write_cfg(REG_KEY_WORD0, k[0]);
    write_cfg(REG_KEY_WORD1, k[1]);
    write_cfg(REG_KEY_WORD2, k[2]);
    write_cfg(REG_KEY_WORD3, k[3]);
  endtask

  task automatic wait_drained();
    while (block_feed_q.size() != 0 || in_valid_i || tea_out_q.size() != 0)
      @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic push_corner_blocks();
    logic [31:0] ys [5] = '{32'h0, 32'hffffffff, 32'h0, 32'h80000000, 32'h7fffffff};
    logic [31:0] zs [5] = '{32'h0, 32'hffffffff, 32'hffffffff, 32'h00000001, 32'h80000000};
    tea_word_t   w;
    for (int c = 0; c < 2; c++) begin
      for (int i = 0; i < 5; i++) begin
        w.cmd  = (c == 0) ? CMD_ENCRYPT : CMD_DECRYPT;
        w.y    = ys[i];
        w.z    = zs[i];
        w.last = i[0];
        block_feed_q.push_back(w);
      end
    end
  endtask

  // encrypts are often followed by a decrypt of their own ciphertext
  task automatic push_random_blocks(input int n);
    tea_word_t  w;
    tea_block_t ct;
    int         k;
    k = 0;
    while (k < n) begin
      w.cmd  = $urandom_range(1) ? CMD_DECRYPT : CMD_ENCRYPT;
      w.y    = rand_word();
      w.z    = rand_word();
      w.last = 1'($urandom_range(1));
      block_feed_q.push_back(w);
      k++;
      if (w.cmd == CMD_ENCRYPT && $urandom_range(1)) begin
        ct     = tea_transform(w, key_mirror);
        w.cmd  = CMD_DECRYPT;
        w.y    = ct.y;
        w.z    = ct.z;
        w.last = 1'($urandom_range(1));
        block_feed_q.push_back(w);
        k++;
      end
    end
  endtask

  always @(posedge clk_i) begin : driver
    tea_word_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) tea_out_q.push_back(tea_transform(word_on_port, key_mirror));
      if (!in_valid_i || !in_stall_o) begin
        if (feed_gap != 0) begin
          feed_gap--;
          in_valid_i <= 1'b0;
        end else if (block_feed_q.size() != 0 && feed_idle_pct != 0 &&
                     $urandom_range(99) < feed_idle_pct) begin
          feed_gap = $urandom_range(15, 0);
          in_valid_i <= 1'b0;
        end else if (block_feed_q.size() != 0) begin
          nxt = block_feed_q.pop_front();
          word_on_port = nxt;
          in_valid_i    <= 1'b1;
          command_i     <= nxt.cmd;
          first_word_i  <= nxt.y;
          second_word_i <= nxt.z;
          last_block_i  <= nxt.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    tea_block_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (tea_out_q.size() == 0) begin
          report_mismatch("unexpected result word, first_result", first_result_o, '0);
        end else begin
          want = tea_out_q.pop_front();
          if (first_result_o !== want.y)
            report_mismatch("first_result", first_result_o, want.y);
          if (second_result_o !== want.z)
            report_mismatch("second_result", second_result_o, want.z);
          if (last_result_o !== want.last)
            report_mismatch("last_result", 32'(last_result_o), 32'(want.last));
        end
      end
      if (drain_gap != 0) drain_gap--;
      else if (drain_stall_pct != 0 && $urandom_range(99) < drain_stall_pct)
        drain_gap = $urandom_range(16, 1);
      out_stall_i <= long_hold || (drain_gap != 0);
    end
  end

  // long output hold so the pipeline and input queue fill up
  initial begin
    wait (hold_start);
    @(posedge clk_i);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    tea_key_t k;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset key is all zero
    push_corner_blocks();
    wait_drained();
    load_key('1);
    push_corner_blocks();
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: k = {32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa};
        3: k = '0;
        6: k = '1;
        default: k = {$urandom, $urandom, $urandom, $urandom};
      endcase
      load_key(k);
      case (ph % 4)
        0: begin feed_idle_pct = 0;  drain_stall_pct = 0;  end
        1: begin feed_idle_pct = 20; drain_stall_pct = 20; end
        2: begin feed_idle_pct = 50; drain_stall_pct = 10; end
        default: begin feed_idle_pct = 10; drain_stall_pct = 50; end
      endcase
      if (ph == PRESSURE_PHASE) begin
        feed_idle_pct   = 0;
        drain_stall_pct = 0;
        hold_start      = 1'b1;
      end
      if (ph == PHASES - 1) begin
        feed_idle_pct   = 0;
        drain_stall_pct = 0;
      end
      push_random_blocks(PHASE_ITEMS);
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
